// ----- hdl/wavetable_tone_with_envelope_defines.svh -----
// assertion macros shared by the checker
`ifndef WAVETABLE_TONE_WITH_ENVELOPE_DEFINES_SVH
`define WAVETABLE_TONE_WITH_ENVELOPE_DEFINES_SVH

// checked only while out of reset
`define WTE_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("wte assertion failed");

// checked at every edge, reset included
`define WTE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("wte assertion failed");

`endif

// ----- hdl/wte_pkg.sv -----
`timescale 1ns / 1ps

package wte_pkg;

    localparam int WAVE_LEN   = 16;
    localparam int INDEX_BITS = 4;
    localparam int VOL_BITS   = 17;
    localparam int STEP_BITS  = 16;
    localparam int DUR_BITS   = 24;
    localparam int SMP_BITS   = 8;

    localparam logic [VOL_BITS-1:0] VOL_FULL          = 17'h10000;
    localparam logic [VOL_BITS-1:0] ENV_STEP_RESET    = 17'd65;
    localparam logic [DUR_BITS-1:0] ENV_SAMPLES_RESET = 24'd1000;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0] {
        CFG_WAVE_LOW,
        CFG_WAVE_HIGH,
        CFG_ENV_STEP,
        CFG_ENV_SAMPLES
    } cfg_index_t;

    typedef struct packed {
        logic [63:0]          wave_low;
        logic [63:0]          wave_high;
        logic [VOL_BITS-1:0]  env_step;
        logic [DUR_BITS-1:0]  env_samples;
    } wte_cfg_t;

    // volume after the envelope update and the table entry it scales
    typedef struct packed {
        logic [VOL_BITS-1:0]  volume;
        logic [SMP_BITS-1:0]  entry;
    } wte_mix_t;

    function automatic logic [SMP_BITS-1:0] table_entry(
        input logic [63:0]           lo,
        input logic [63:0]           hi,
        input logic [INDEX_BITS-1:0] idx
    );
        logic [63:0] word;
        word = idx[INDEX_BITS-1] ? hi : lo;
        return word[{idx[INDEX_BITS-2:0], 3'b000} +: SMP_BITS];
    endfunction

endpackage

// ----- hdl/wte_voice.sv -----
`timescale 1ns / 1ps

module wte_voice #(
    parameter int PHASE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          command,
    input  logic [wte_pkg::STEP_BITS-1:0] phase_step,
    input  logic [wte_pkg::DUR_BITS-1:0]  duration_samples,
    input  wte_pkg::wte_cfg_t             cfg,
    input  logic                          drain,
    output logic                          mix_valid,
    output wte_pkg::wte_mix_t             mix
);

    localparam int SUM_BITS = (PHASE_BITS > wte_pkg::STEP_BITS) ?
                              PHASE_BITS : wte_pkg::STEP_BITS;

    logic [PHASE_BITS-1:0]          phase_reg, phase_next;
    logic [wte_pkg::VOL_BITS-1:0]   volume_reg, volume_next;
    logic [wte_pkg::DUR_BITS-1:0]   remaining_reg, remaining_next;
    logic [wte_pkg::STEP_BITS-1:0]  tone_step_reg;
    logic                           mix_valid_reg, mix_valid_next;
    wte_pkg::wte_mix_t              mix_reg, mix_next;

    logic [wte_pkg::VOL_BITS:0]     vol_sum;
    logic [SUM_BITS-1:0]            phase_sum;
    logic                           tick;

    assign tick = accept && (command == wte_pkg::CMD_TICK);

    always_comb begin
        vol_sum = {1'b0, volume_reg} + {1'b0, cfg.env_step};
        if (remaining_reg > cfg.env_samples) begin
            volume_next = (vol_sum > {1'b0, wte_pkg::VOL_FULL}) ?
                          wte_pkg::VOL_FULL : vol_sum[wte_pkg::VOL_BITS-1:0];
        end else begin
            volume_next = (volume_reg > cfg.env_step) ?
                          (volume_reg - cfg.env_step) : '0;
        end

        phase_sum  = SUM_BITS'(phase_reg) + SUM_BITS'(tone_step_reg);
        phase_next = phase_sum[PHASE_BITS-1:0];

        remaining_next = (remaining_reg != '0) ?
                         (remaining_reg - wte_pkg::DUR_BITS'(1)) : remaining_reg;

        mix_next.volume = volume_next;
        mix_next.entry  = wte_pkg::table_entry(cfg.wave_low, cfg.wave_high,
                              phase_reg[PHASE_BITS-1 -: wte_pkg::INDEX_BITS]);

        if (tick) begin
            mix_valid_next = 1'b1;
        end else if (drain) begin
            mix_valid_next = 1'b0;
        end else begin
            mix_valid_next = mix_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            volume_reg    <= '0;
            remaining_reg <= '0;
            tone_step_reg <= '0;
            mix_valid_reg <= 1'b0;
        end else begin
            mix_valid_reg <= mix_valid_next;
            if (accept && (command == wte_pkg::CMD_START)) begin
                // phase and volume carry over so a restart does not click
                tone_step_reg <= phase_step;
                remaining_reg <= duration_samples;
            end else if (tick) begin
                volume_reg    <= volume_next;
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            mix_reg <= mix_next;
        end
    end

    assign mix_valid = mix_valid_reg;
    assign mix       = mix_reg;

endmodule

// ----- hdl/wte_scale.sv -----
`timescale 1ns / 1ps

module wte_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         mix_valid,
    input  wte_pkg::wte_mix_t            mix,
    output logic                         out_free,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [wte_pkg::SMP_BITS-1:0] m_sample
);

    localparam int PROD_BITS = wte_pkg::VOL_BITS + wte_pkg::SMP_BITS;

    logic                         m_valid_reg;
    logic [wte_pkg::SMP_BITS-1:0] sample_reg, sample_next;
    logic [PROD_BITS-1:0]         product;
    logic                         load;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = mix_valid && out_free;

    // full volume times 255 lands exactly on 255, so no clamp is needed
    always_comb begin
        product     = PROD_BITS'(mix.volume) * PROD_BITS'(mix.entry);
        sample_next = product[16 +: wte_pkg::SMP_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= mix_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sample_reg <= sample_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = sample_reg;

endmodule

// ----- hdl/wavetable_tone_with_envelope.sv -----
`timescale 1ns / 1ps

// Wavetable tone generator with a linear attack/release envelope. A start
// transfer (command 1) loads the phase step and the beep length; each tick
// transfer (command 0) yields one 8-bit sample, a start yields none. The block
// takes one transfer per cycle unless the input stalls. Behind the transfer of a
// tick, one register stage holds the updated volume and the chosen table
// entry, the next holds the scaled sample. The input stalls only when both
// stages are full and the output is not taken. Configuration writes are
// accepted at every cycle and belong only between beeps, while idle.
module wavetable_tone_with_envelope #(
    parameter int PHASE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [wte_pkg::STEP_BITS-1:0] s_phase_step,
    input  logic [wte_pkg::DUR_BITS-1:0]  s_duration_samples,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wte_pkg::SMP_BITS-1:0]  m_sample,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [63:0]                   cfg_data
);

    wte_pkg::wte_cfg_t cfg_reg;
    wte_pkg::wte_mix_t mix;
    logic              mix_valid;
    logic              out_free;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !mix_valid || out_free;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wave_low    <= '0;
            cfg_reg.wave_high   <= '0;
            cfg_reg.env_step    <= wte_pkg::ENV_STEP_RESET;
            cfg_reg.env_samples <= wte_pkg::ENV_SAMPLES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (wte_pkg::cfg_index_t'(cfg_index))
                wte_pkg::CFG_WAVE_LOW:    cfg_reg.wave_low  <= cfg_data;
                wte_pkg::CFG_WAVE_HIGH:   cfg_reg.wave_high <= cfg_data;
                wte_pkg::CFG_ENV_STEP:
                    cfg_reg.env_step <= cfg_data[wte_pkg::VOL_BITS-1:0];
                wte_pkg::CFG_ENV_SAMPLES:
                    cfg_reg.env_samples <= cfg_data[wte_pkg::DUR_BITS-1:0];
                default: ;
            endcase
        end
    end

    wte_voice #(
        .PHASE_BITS(PHASE_BITS)
    ) u_voice (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .command          (s_command),
        .phase_step       (s_phase_step),
        .duration_samples (s_duration_samples),
        .cfg              (cfg_reg),
        .drain            (out_free),
        .mix_valid        (mix_valid),
        .mix              (mix)
    );

    wte_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mix_valid (mix_valid),
        .mix       (mix),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sample  (m_sample)
    );

endmodule

// ----- hdl/wte_checker.sv -----
`timescale 1ns / 1ps
`include "wavetable_tone_with_envelope_defines.svh"

module wte_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_command,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [wte_pkg::SMP_BITS-1:0]  m_sample,
    input logic                          cfg_ready
);

    logic tick_xfer;

    assign tick_xfer = s_valid && s_ready && (s_command == wte_pkg::CMD_TICK);

    `WTE_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid)
    `WTE_ASSERT(a_out_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_sample))
    // a fresh result always traces back to a tick through the voice and scale registers
    `WTE_ASSERT(a_rise_from_tick, aclk, aresetn, $rose(m_valid) |-> $past(tick_xfer, 2))
    `WTE_ASSERT(a_cfg_open, aclk, aresetn, cfg_ready)

endmodule

bind wavetable_tone_with_envelope wte_checker u_wte_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_command (s_command),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_sample  (m_sample),
    .cfg_ready (cfg_ready)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import wte_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 110;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_TICK;
    logic [STEP_BITS-1:0] s_phase_step = '0;
    logic [DUR_BITS-1:0]  s_duration_samples = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SMP_BITS-1:0]  m_sample;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = CFG_WAVE_LOW;
    logic [63:0]          cfg_data = '0;

    // tone model state and its copy of the registers
    wte_cfg_t             model_cfg;
    logic [15:0]          tone_phase;
    logic [15:0]          tone_incr;
    logic [VOL_BITS-1:0]  tone_volume;
    logic [DUR_BITS-1:0]  tone_left;

    logic [SMP_BITS-1:0]  pending_samples[$];
    logic [SMP_BITS-1:0]  want_sample;
    int                   errors = 0;
    int                   quiet_cycles = 0;
    bit                   idle_on = 1'b1;
    bit                   hold_req = 1'b0;
    int                   rx_wait = 0;

    wavetable_tone_with_envelope u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_phase_step       (s_phase_step),
        .s_duration_samples (s_duration_samples),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sample           (m_sample),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void tone_reset();
        model_cfg.wave_low    = '0;
        model_cfg.wave_high   = '0;
        model_cfg.env_step    = ENV_STEP_RESET;
        model_cfg.env_samples = ENV_SAMPLES_RESET;
        tone_phase  = '0;
        tone_incr   = '0;
        tone_volume = '0;
        tone_left   = '0;
    endfunction

    function automatic void tone_start(input logic [15:0] incr, input logic [DUR_BITS-1:0] len);
        tone_incr = incr;
        tone_left = len;
    endfunction

    // envelope, then lookup at the old phase, then phase and count advance
    function automatic logic [SMP_BITS-1:0] tone_tick();
        logic [VOL_BITS:0]   raised;
        logic [127:0]        wave;
        logic [7:0]          entry;
        logic [VOL_BITS+7:0] product;
        if (tone_left > model_cfg.env_samples) begin
            raised = {1'b0, tone_volume} + {1'b0, model_cfg.env_step};
            tone_volume = (raised > {1'b0, VOL_FULL}) ? VOL_FULL : raised[VOL_BITS-1:0];
        end else begin
            tone_volume = (tone_volume > model_cfg.env_step) ?
                          tone_volume - model_cfg.env_step : '0;
        end
        wave    = {model_cfg.wave_high, model_cfg.wave_low};
        entry   = wave[{tone_phase[15:12], 3'b000} +: 8];
        product = (VOL_BITS+8)'(tone_volume) * (VOL_BITS+8)'(entry);
        tone_phase = tone_phase + tone_incr;
        if (tone_left != 0) begin
            tone_left = tone_left - DUR_BITS'(1);
        end
        return (product[VOL_BITS+7:16] > 255) ? 8'hFF : product[23:16];
    endfunction

    // result side: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            rx_wait  = HOLD_CYCLES;
        end
        if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            rx_wait = $urandom_range(0, 9);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: sample with none expected, expected none actual %0d",
                         $time, m_sample);
                errors++;
            end else begin
                want_sample = pending_samples.pop_front();
                if (m_sample !== want_sample) begin
                    $display("%0t: sample mismatch, expected %0d actual %0d",
                             $time, want_sample, m_sample);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // leaves valid high after the transfer so back-to-back items need no toggle
    task automatic send_item(input logic cmd, input logic [15:0] incr,
                             input logic [DUR_BITS-1:0] len);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_command          <= cmd;
        s_phase_step       <= incr;
        s_duration_samples <= len;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_START) begin
            tone_start(incr, len);
        end else begin
            pending_samples.push_back(tone_tick());
        end
    endtask

    task automatic send_random_item();
        logic                cmd;
        logic [DUR_BITS-1:0] len;
        cmd = ($urandom_range(0, 15) == 0) ? CMD_START : CMD_TICK;
        len = ($urandom_range(0, 9) == 0) ? DUR_BITS'($urandom) :
                                            DUR_BITS'($urandom_range(0, 300));
        send_item(cmd, 16'($urandom_range(0, 65535)), len);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        // starts leave nothing to wait for, give them time to clear the pipeline
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WAVE_LOW:    model_cfg.wave_low    = data;
            CFG_WAVE_HIGH:   model_cfg.wave_high   = data;
            CFG_ENV_STEP:    model_cfg.env_step    = data[VOL_BITS-1:0];
            CFG_ENV_SAMPLES: model_cfg.env_samples = data[DUR_BITS-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_silence();
        // nothing playing and an all-zero table
        send_item(CMD_TICK, 16'hFFFF, 24'hFFFFFF);
        send_item(CMD_TICK, 16'h0000, 24'h000000);
        wait_idle();
    endtask

    task automatic test_directed_beeps();
        cfg_write(CFG_WAVE_LOW,    64'h7F40_2010_0804_01FF);
        cfg_write(CFG_WAVE_HIGH,   64'h0080_C0E0_F0F8_FCFE);
        cfg_write(CFG_ENV_STEP,    {47'd0, VOL_FULL});
        cfg_write(CFG_ENV_SAMPLES, 64'd4);
        // one table entry per sample at full volume
        send_item(CMD_START, 16'h1000, 24'd12);
        repeat (8) send_item(CMD_TICK, 16'h0000, 24'h0);
        // restart mid-beep keeps phase and volume
        send_item(CMD_START, 16'hFFFF, 24'hFFFFFF);
        repeat (3) send_item(CMD_TICK, 16'h0000, 24'h0);
        wait_idle();
        // zero step holds the volume even while releasing
        cfg_write(CFG_ENV_STEP, 64'd0);
        send_item(CMD_START, 16'h0000, 24'd0);
        repeat (2) send_item(CMD_TICK, 16'h0000, 24'h0);
        wait_idle();
        // oversized step must still saturate at both ends
        cfg_write(CFG_ENV_STEP, 64'h1_FFFF);
        repeat (2) send_item(CMD_TICK, 16'h0000, 24'h0);
        send_item(CMD_START, 16'h8000, 24'd40);
        repeat (2) send_item(CMD_TICK, 16'h0000, 24'h0);
        wait_idle();
    endtask

    task automatic test_random_beeps();
        logic [63:0] junk;
        logic [63:0] step_val;
        logic [63:0] env_val;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            junk = {$urandom, $urandom};
            case (p)
                0:       step_val = 64'd1;
                1:       step_val = {47'd0, VOL_FULL};
                2:       step_val = 64'd0;
                3:       step_val = 64'h1_FFFF;
                4:       step_val = {junk[63:17], 17'($urandom)};
                default: step_val = 64'($urandom_range(1, 8192));
            endcase
            case (p)
                0:       env_val = 64'd0;
                1:       env_val = 64'hFF_FFFF;
                6:       env_val = {junk[63:24], 24'($urandom)};
                default: env_val = 64'($urandom_range(0, 150));
            endcase
            cfg_write(CFG_ENV_STEP, step_val);
            cfg_write(CFG_ENV_SAMPLES, env_val);
            case (p)
                4: begin
                    cfg_write(CFG_WAVE_LOW,  '1);
                    cfg_write(CFG_WAVE_HIGH, '1);
                end
                5: begin
                    cfg_write(CFG_WAVE_LOW,  '0);
                    cfg_write(CFG_WAVE_HIGH, '0);
                end
                default: begin
                    cfg_write(CFG_WAVE_LOW,  {$urandom, $urandom});
                    cfg_write(CFG_WAVE_HIGH, {$urandom, $urandom});
                end
            endcase
            repeat (PHASE_ITEMS) send_random_item();
            wait_idle();
        end
    endtask

    task automatic test_output_hold_off();
        cfg_write(CFG_ENV_STEP, 64'd2000);
        cfg_write(CFG_ENV_SAMPLES, 64'd20);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        send_item(CMD_START, 16'h0731, 24'd50);
        repeat (60) send_random_item();
        wait_idle();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        cfg_write(CFG_ENV_STEP, 64'd700);
        cfg_write(CFG_ENV_SAMPLES, 64'd60);
        send_item(CMD_START, 16'h0A3D, 24'd120);
        repeat (80) send_random_item();
        wait_idle();
    endtask

    initial begin
        tone_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_silence();
        test_directed_beeps();
        test_random_beeps();
        test_output_hold_off();
        test_full_rate();
        repeat (20) @(posedge aclk);
        if (pending_samples.size() != 0) begin
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
